[rtl/wrsi_pkg.sv]
// Shared types and constants for the Wilder RSI stream block.
// Used by wrsi_div, wrsi_dpath, wrsi_ctrl and wilder_rsi_stream; depends on nothing.
package wrsi_pkg;

  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int AVG_W      = 48;
  localparam int WIN_W      = 8;
  localparam int RSI_W      = 14;
  localparam int MULB_W     = 14;
  localparam int PROD_W     = AVG_W + MULB_W;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = AVG_W + 1;

  localparam logic [WIN_W-1:0] WIN_RESET  = 8'd14;
  localparam logic [WIN_W-1:0] WIN_MIN    = 8'd2;
  localparam logic [WIN_W-1:0] CNT_SEEDED = 8'hFF;
  localparam logic [RSI_W-1:0] RSI_FULL   = 14'd10000;
  localparam logic [AVG_W-1:0] AVG_MAX    = {AVG_W{1'b1}};

  // Which average an arithmetic step works on.
  typedef enum logic [1:0] {
    OP_GAIN = 2'b00,
    OP_LOSS = 2'b01,
    OP_RSI  = 2'b10
  } op_e;

  typedef struct packed {
    logic capture;   // latch the input beat
    logic eval;      // apply price change to state
    logic mul_en;    // register one product
    logic div_load;  // start the divider
    logic div_wb;    // write the quotient back
    logic set_full;  // result is 100 percent
    logic emit;      // load the output register
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic first;      // first price of a series
    logic no_result;  // still seeding, nothing to report
    logic loss_zero;
    logic out_free;
  } sts_t;

endpackage

[rtl/wilder_rsi_stream.sv]
// Streaming RSI with Wilder smoothing: top level joining controller,
// datapath and shared divider. Depends on wrsi_pkg, wrsi_ctrl, wrsi_dpath, wrsi_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one price beat plus a
//   start_series flag. Output channel (out_valid_o/out_ready_i) carries one
//   RSI beat in hundredths of a percent. cfg_valid_i/cfg_ready_o writes the
//   window length; it is always ready and should only be written while idle.
//   A first price or a seeding change gives no result, and the next beat can
//   be taken once it has been applied to the state. A change that reports runs
//   three passes of the shared divider (gain, loss, ratio), each of one
//   multiply, one load, 64 one-bit divide steps and one write back. The next
//   input beat is taken only once its result has loaded the output register.
//   When the average loss is zero the ratio pass is skipped. One price beat
//   is in work at a time, so the divider sets the throughput.
//   Reset: window length returns to 14, the series is cleared, no result is
//   pending. Stall: a result waits in the output register while out_ready_i
//   is low; the next beat is still taken and worked up to the point where
//   its own result would load that register.
module wilder_rsi_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [wrsi_pkg::PRICE_BITS-1:0] price_i,
  input  logic                            start_series_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wrsi_pkg::RSI_W-1:0]      rsi_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wrsi_pkg::WIN_W-1:0]      window_length_i
);

  wrsi_pkg::cmd_t                   cmd;
  wrsi_pkg::sts_t                   sts;
  logic [wrsi_pkg::DIV_NUM_W-1:0]   div_num;
  logic [wrsi_pkg::DIV_DEN_W-1:0]   div_den;
  logic [wrsi_pkg::DIV_NUM_W-1:0]   div_quot;
  logic                             div_done;

  // Window writes are registered directly; never back-pressure.
  assign cfg_ready_o = 1'b1;

  wrsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .div_done_i (div_done),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  wrsi_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .price_i         (price_i),
    .start_series_i  (start_series_i),
    .cfg_we_i        (cfg_valid_i),
    .window_length_i (window_length_i),
    .out_ready_i     (out_ready_i),
    .quot_i          (div_quot),
    .num_o           (div_num),
    .den_o           (div_den),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .rsi_value_o     (rsi_value_o)
  );

  // Shared by the gain, loss and ratio divisions.
  wrsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.div_load),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

endmodule

[rtl/wrsi_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on wrsi_pkg for operand widths.
module wrsi_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wrsi_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [wrsi_pkg::DIV_DEN_W-1:0] den_i,
  output logic [wrsi_pkg::DIV_NUM_W-1:0] quot_o,
  output logic                           done_o
);

  localparam int NW   = wrsi_pkg::DIV_NUM_W;
  localparam int DW   = wrsi_pkg::DIV_DEN_W;
  localparam int CW   = $clog2(NW);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

[rtl/wrsi_dpath.sv]
// Datapath: series state, window register, shared multiplier, operand muxes
// for the divider and the output register. Depends on wrsi_pkg.
module wrsi_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wrsi_pkg::cmd_t                    cmd_i,
  input  logic [wrsi_pkg::PRICE_BITS-1:0]   price_i,
  input  logic                              start_series_i,
  input  logic                              cfg_we_i,
  input  logic [wrsi_pkg::WIN_W-1:0]        window_length_i,
  input  logic                              out_ready_i,
  input  logic [wrsi_pkg::DIV_NUM_W-1:0]    quot_i,
  output logic [wrsi_pkg::DIV_NUM_W-1:0]    num_o,
  output logic [wrsi_pkg::DIV_DEN_W-1:0]    den_o,
  output wrsi_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  output logic [wrsi_pkg::RSI_W-1:0]        rsi_value_o
);

  localparam int PW = wrsi_pkg::PRICE_BITS;
  localparam int AW = wrsi_pkg::AVG_W;
  localparam int WW = wrsi_pkg::WIN_W;
  localparam int NW = wrsi_pkg::DIV_NUM_W;
  localparam int DW = wrsi_pkg::DIV_DEN_W;
  localparam int RW = wrsi_pkg::RSI_W;
  localparam int BW = wrsi_pkg::MULB_W;
  localparam int QW = wrsi_pkg::PROD_W;

  logic [WW-1:0] win_q;
  logic [PW-1:0] prev_q;
  logic          have_prev_q;
  logic [WW-1:0] cnt_q;
  logic [AW-1:0] avg_g_q, avg_l_q;
  logic          seed_q;
  logic          out_valid_q;

  logic [PW-1:0] price_q;
  logic          start_q;
  logic [PW-1:0] gain_q, loss_q;
  logic [QW-1:0] prod_q;
  logic [RW-1:0] res_q;
  logic [RW-1:0] rsi_q;

  logic [WW-1:0] n_eff, n_m1;
  logic [WW:0]   cnt_inc;
  logic          first, seeded, seed_end;
  logic [PW-1:0] gain, loss;
  logic [AW:0]   sum_g, sum_l;
  logic [AW-1:0] mul_a, quot_sat;
  logic [BW-1:0] mul_b;
  logic [QW-1:0] mul_p;

  assign n_eff    = (win_q < wrsi_pkg::WIN_MIN) ? wrsi_pkg::WIN_MIN : win_q;
  assign n_m1     = n_eff - WW'(1);
  assign cnt_inc  = {1'b0, cnt_q} + (WW+1)'(1);
  assign first    = start_q || !have_prev_q;
  assign seeded   = cnt_q == wrsi_pkg::CNT_SEEDED;
  assign seed_end = cnt_inc >= {1'b0, n_eff};

  assign gain  = (price_q >= prev_q) ? (price_q - prev_q) : '0;
  assign loss  = (price_q >= prev_q) ? '0 : (prev_q - price_q);
  assign sum_g = {1'b0, avg_g_q} + (AW+1)'(gain);
  assign sum_l = {1'b0, avg_l_q} + (AW+1)'(loss);

  assign mul_a = (cmd_i.op == wrsi_pkg::OP_LOSS) ? avg_l_q : avg_g_q;
  assign mul_b = (cmd_i.op == wrsi_pkg::OP_RSI) ? wrsi_pkg::RSI_FULL : BW'(n_m1);
  assign mul_p = mul_a * mul_b;

  // Seed quotients can overflow the average width; clamp.
  assign quot_sat = (|quot_i[NW-1:AW]) ? wrsi_pkg::AVG_MAX : quot_i[AW-1:0];

  always_comb begin
    case (cmd_i.op)
      wrsi_pkg::OP_GAIN: begin
        num_o = seed_q ? (NW'(avg_g_q) << wrsi_pkg::FRAC_BITS)
                       : (NW'(prod_q) + (NW'(gain_q) << wrsi_pkg::FRAC_BITS));
        den_o = DW'(n_eff);
      end
      wrsi_pkg::OP_LOSS: begin
        num_o = seed_q ? (NW'(avg_l_q) << wrsi_pkg::FRAC_BITS)
                       : (NW'(prod_q) + (NW'(loss_q) << wrsi_pkg::FRAC_BITS));
        den_o = DW'(n_eff);
      end
      wrsi_pkg::OP_RSI: begin
        num_o = NW'(prod_q);
        den_o = {1'b0, avg_g_q} + {1'b0, avg_l_q};
      end
      default: begin
        num_o = '0;
        den_o = DW'(n_eff);
      end
    endcase
  end

  assign sts_o.first     = first;
  assign sts_o.no_result = !first && !seeded && !seed_end;
  assign sts_o.loss_zero = avg_l_q == '0;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= wrsi_pkg::WIN_RESET;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      cnt_q       <= '0;
      avg_g_q     <= '0;
      avg_l_q     <= '0;
      seed_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= window_length_i;
      end
      if (cmd_i.eval) begin
        prev_q      <= price_q;
        have_prev_q <= 1'b1;
        if (first) begin
          cnt_q   <= '0;
          avg_g_q <= '0;
          avg_l_q <= '0;
        end else if (!seeded) begin
          avg_g_q <= sum_g[AW] ? wrsi_pkg::AVG_MAX : sum_g[AW-1:0];
          avg_l_q <= sum_l[AW] ? wrsi_pkg::AVG_MAX : sum_l[AW-1:0];
          cnt_q   <= seed_end ? wrsi_pkg::CNT_SEEDED : cnt_inc[WW-1:0];
        end
        seed_q <= !seeded;
      end
      if (cmd_i.div_wb) begin
        if (cmd_i.op == wrsi_pkg::OP_GAIN) begin
          avg_g_q <= quot_sat;
        end
        if (cmd_i.op == wrsi_pkg::OP_LOSS) begin
          avg_l_q <= quot_sat;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat, change and product registers; the new result waits in res_q until the output register is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      price_q <= price_i;
      start_q <= start_series_i;
    end
    if (cmd_i.eval) begin
      gain_q <= gain;
      loss_q <= loss;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.div_wb && cmd_i.op == wrsi_pkg::OP_RSI) begin
      res_q <= quot_i[RW-1:0];
    end else if (cmd_i.set_full) begin
      res_q <= wrsi_pkg::RSI_FULL;
    end
    if (cmd_i.emit) begin
      rsi_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsi_value_o = rsi_q;

endmodule

[rtl/wrsi_ctrl.sv]
// Controller: sequences capture, update, up to three multiply/divide passes
// and the output load. Depends on wrsi_pkg.
module wrsi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           div_done_i,
  input  wrsi_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output wrsi_pkg::cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_EVAL   = 12'b0000_0000_0010,
    S_MUL_G  = 12'b0000_0000_0100,
    S_LOAD_G = 12'b0000_0000_1000,
    S_DIV_G  = 12'b0000_0001_0000,
    S_MUL_L  = 12'b0000_0010_0000,
    S_LOAD_L = 12'b0000_0100_0000,
    S_DIV_L  = 12'b0000_1000_0000,
    S_MUL_R  = 12'b0001_0000_0000,
    S_LOAD_R = 12'b0010_0000_0000,
    S_DIV_R  = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.op = wrsi_pkg::OP_GAIN;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.first || sts_i.no_result) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_MUL_G;
        end
      end
      S_MUL_G: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_LOAD_G;
      end
      S_LOAD_G: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DIV_G;
      end
      S_DIV_G: begin
        if (div_done_i) begin
          cmd_o.div_wb = 1'b1;
          state_d = S_MUL_L;
        end
      end
      S_MUL_L: begin
        cmd_o.op = wrsi_pkg::OP_LOSS;
        cmd_o.mul_en = 1'b1;
        state_d = S_LOAD_L;
      end
      S_LOAD_L: begin
        cmd_o.op = wrsi_pkg::OP_LOSS;
        cmd_o.div_load = 1'b1;
        state_d = S_DIV_L;
      end
      S_DIV_L: begin
        cmd_o.op = wrsi_pkg::OP_LOSS;
        if (div_done_i) begin
          cmd_o.div_wb = 1'b1;
          state_d = S_MUL_R;
        end
      end
      S_MUL_R: begin
        cmd_o.op = wrsi_pkg::OP_RSI;
        cmd_o.mul_en = 1'b1;
        if (sts_i.loss_zero) begin
          cmd_o.set_full = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_LOAD_R;
        end
      end
      S_LOAD_R: begin
        cmd_o.op = wrsi_pkg::OP_RSI;
        cmd_o.div_load = 1'b1;
        state_d = S_DIV_R;
      end
      S_DIV_R: begin
        cmd_o.op = wrsi_pkg::OP_RSI;
        if (div_done_i) begin
          cmd_o.div_wb = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[tb/wilder_rsi_stream_test.sv]
// Self-checking testbench for wilder_rsi_stream: streams price beats, predicts every
// RSI beat with a local fixed-point model and checks the results in order.
// Depends on wrsi_pkg and the wilder_rsi_stream RTL.
module wilder_rsi_stream_test;

  localparam int          HALF_PERIOD  = 4;
  // Drain time, longer than a reporting beat takes to work through.
  localparam int          DRAIN_CYCLES = 240;
  localparam logic [63:0] AVG_LIMIT    = 64'(wrsi_pkg::AVG_MAX);

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            in_valid_i      = 1'b0;
  logic                            in_ready_o;
  logic [wrsi_pkg::PRICE_BITS-1:0] price_i         = '0;
  logic                            start_series_i  = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i     = 1'b0;
  logic [wrsi_pkg::RSI_W-1:0]      rsi_value_o;
  logic                            cfg_valid_i     = 1'b0;
  logic                            cfg_ready_o;
  logic [wrsi_pkg::WIN_W-1:0]      window_length_i = '0;

  // Local copy of the block's state and its window register.
  logic [wrsi_pkg::WIN_W-1:0]      win_len    = wrsi_pkg::WIN_RESET;
  logic [wrsi_pkg::PRICE_BITS-1:0] prev_price = '0;
  logic                            have_prev  = 1'b0;
  logic [wrsi_pkg::WIN_W-1:0]      chg_count  = '0;
  logic [63:0]                     mean_up    = '0;
  logic [63:0]                     mean_down  = '0;

  // RSI beats still owed by the block, oldest first.
  logic [wrsi_pkg::RSI_W-1:0]      rsi_due[$];
  logic [wrsi_pkg::RSI_W-1:0]      rsi_want;

  int                              err_count  = 0;
  int                              burst_left = 0;
  int                              stall_left = 0;
  bit                              gap_on     = 1'b1;
  bit                              stall_on   = 1'b1;

  wilder_rsi_stream uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .price_i         (price_i),
    .start_series_i  (start_series_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .rsi_value_o     (rsi_value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .window_length_i (window_length_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #24_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the averages (48-bit values held in 64 bits).
  // ---------------------------------------------------------------------------

  // Add and clip at the 48-bit ceiling.
  function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > AVG_LIMIT || s < a) ? AVG_LIMIT : s;
  endfunction

  // Move a raw price change into the fraction format, clipping on overflow.
  function automatic logic [63:0] to_fixed(input logic [63:0] x);
    if (x > (AVG_LIMIT >> wrsi_pkg::FRAC_BITS)) return AVG_LIMIT;
    return x << wrsi_pkg::FRAC_BITS;
  endfunction

  // Turn a plain seeding sum into a fixed-point mean over n changes.
  function automatic logic [63:0] seed_mean(input logic [63:0] sum, input logic [63:0] n);
    logic [63:0] q;
    logic [63:0] r;
    q = sum / n;
    r = sum % n;
    if (q > (AVG_LIMIT >> wrsi_pkg::FRAC_BITS)) return AVG_LIMIT;
    return clip_add(q << wrsi_pkg::FRAC_BITS, (r << wrsi_pkg::FRAC_BITS) / n);
  endfunction

  // One Wilder smoothing step: (avg*(n-1) + x) / n, truncated.
  function automatic logic [63:0] wilder_step(input logic [63:0] avg, input logic [63:0] x,
                                              input logic [63:0] n);
    return (avg * (n - 64'd1) + x) / n;
  endfunction

  // RSI in hundredths of a percent; full scale whenever the loss side is zero.
  function automatic logic [wrsi_pkg::RSI_W-1:0] rsi_ratio(input logic [63:0] g,
                                                           input logic [63:0] l);
    logic [63:0] q;
    if (l == 64'd0) return wrsi_pkg::RSI_FULL;
    q = (64'(wrsi_pkg::RSI_FULL) * g) / (g + l);
    return q[wrsi_pkg::RSI_W-1:0];
  endfunction

  // Advance the local state by one accepted price beat and queue its RSI, if any.
  task automatic track_price(input logic [wrsi_pkg::PRICE_BITS-1:0] p, input logic s);
    logic [63:0] n;
    logic [63:0] up;
    logic [63:0] down;
    n = (win_len < wrsi_pkg::WIN_MIN) ? 64'(wrsi_pkg::WIN_MIN) : 64'(win_len);
    // A start flag or the first beat after reset opens a new series.
    if (s || !have_prev) begin
      prev_price = p;
      have_prev  = 1'b1;
      chg_count  = '0;
      mean_up    = '0;
      mean_down  = '0;
      return;
    end
    up   = (p >= prev_price) ? 64'(p) - 64'(prev_price) : 64'd0;
    down = (p <  prev_price) ? 64'(prev_price) - 64'(p) : 64'd0;
    prev_price = p;
    if (chg_count != wrsi_pkg::CNT_SEEDED) begin
      // Seeding: plain sums until the count reaches the window in force now.
      mean_up   = clip_add(mean_up, up);
      mean_down = clip_add(mean_down, down);
      chg_count = chg_count + 8'd1;
      if (64'(chg_count) < n) return;
      mean_up   = seed_mean(mean_up, n);
      mean_down = seed_mean(mean_down, n);
      // Park the count: later window writes never reopen seeding.
      chg_count = wrsi_pkg::CNT_SEEDED;
    end else begin
      mean_up   = wilder_step(mean_up, to_fixed(up), n);
      mean_down = wilder_step(mean_down, to_fixed(down), n);
    end
    rsi_due.insert(rsi_due.size(), rsi_ratio(mean_up, mean_down));
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Compare every RSI beat that leaves the block with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsi_due.size() == 0) begin
        report_error($sformatf("rsi beat %0d with nothing pending", rsi_value_o));
      end else begin
        rsi_want = rsi_due.pop_front();
        if (rsi_value_o !== rsi_want)
          report_error($sformatf("rsi_value %0d, want %0d", rsi_value_o, rsi_want));
      end
    end
  end

  // Receiver: short blips plus occasional long stalls that outlast a whole
  // computation, so the next beat gets worked while a result is held.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (stall_on && $urandom_range(0, 299) == 0)
        stall_left = $urandom_range(1, 320);
      else if (stall_on && $urandom_range(0, 19) == 0)
        stall_left = $urandom_range(1, 3);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one price beat. The sender works in bursts; between bursts drop valid
  // for a random gap, long enough at times to land on any phase of the work.
  task automatic send_price(input logic [wrsi_pkg::PRICE_BITS-1:0] p, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (gap_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 260) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    price_i        <= p;
    start_series_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    track_price(p, s);
  endtask

  // Hold the sender until every owed result has come, then let the block go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (rsi_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the window length, only once the block is idle.
  task automatic set_window(input logic [wrsi_pkg::WIN_W-1:0] w);
    settle();
    cfg_valid_i     <= 1'b1;
    window_length_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_len = w;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset window of 14, with full-scale swings in the seeding sums.
  task automatic test_default_window();
    send_price('0, 1'b1);
    send_price('1, 1'b0);
    send_price('0, 1'b0);
    send_price('1, 1'b0);
    send_price(32'h8000_0000, 1'b0);
    repeat (11) send_price($urandom, 1'b0);
  endtask

  // Window 0 acts as 2: flat prices, gain-only, restart mid-series, loss-only.
  task automatic test_short_window();
    set_window(8'd0);
    send_price(32'd7, 1'b1);
    send_price(32'd7, 1'b0);
    send_price(32'd7, 1'b0);
    send_price(32'd9, 1'b0);
    send_price(32'd5, 1'b1);
    send_price(32'd3, 1'b0);
    send_price(32'd3, 1'b0);
  endtask

  // Shrink the window while seeding: seeding ends at the next change.
  task automatic test_window_change_seeding();
    set_window(8'd255);
    send_price(32'd10, 1'b1);
    send_price(32'd11, 1'b0);
    send_price(32'd12, 1'b0);
    set_window(8'd2);
    send_price(32'd13, 1'b0);
  endtask

  // Widen the window after seeding: only the smoothing N changes.
  task automatic test_window_change_seeded();
    set_window(8'd255);
    send_price(32'd9, 1'b0);
  endtask

  // Random walks over several window settings, with noise and broken series.
  task automatic test_random_walk();
    logic [wrsi_pkg::PRICE_BITS-1:0] price;
    logic [wrsi_pkg::PRICE_BITS-1:0] step;
    int unsigned                     win;
    int unsigned                     cnt;
    int unsigned                     sel;
    price = '0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin win = 14;  cnt = 130; end
        1:       begin win = 2;   cnt = 120; end
        2:       begin win = 255; cnt = 290; end
        3:       begin win = 1;   cnt = 60;  end
        4:       begin win = 3;   cnt = 100; end
        5:       begin win = $urandom_range(4, 40);  cnt = 130; end
        6:       begin win = 7;   cnt = 60;  end
        default: begin win = $urandom_range(2, 255); cnt = 130; end
      endcase
      set_window(win[wrsi_pkg::WIN_W-1:0]);
      // One phase runs with no idling on either side.
      gap_on   = (ph != 4);
      stall_on = (ph != 4);
      for (int k = 0; k < cnt; k++) begin
        // Pause mid-series until the pipeline is empty.
        if (ph == 2 && k == cnt / 2) settle();
        sel = $urandom_range(0, 99);
        if (k == 0 || sel < 2) begin
          price = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1000);
          send_price(price, 1'b1);
        end else if (sel < 5) begin
          // Noise: a jump to anywhere in the price range.
          price = $urandom;
          send_price(price, 1'b0);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: step = $urandom_range(0, 255);
            6, 7:             step = $urandom_range(0, 65535);
            8:                step = $urandom;
            default:          step = '0;
          endcase
          price = ($urandom_range(0, 1) == 1) ? price + step : price - step;
          send_price(price, 1'b0);
        end
      end
    end
    gap_on   = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_default_window();
    test_short_window();
    test_window_change_seeding();
    test_window_change_seeded();
    test_random_walk();
    settle();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/wrsi_pkg.sv
rtl/wrsi_div.sv
rtl/wrsi_dpath.sv
rtl/wrsi_ctrl.sv
rtl/wilder_rsi_stream.sv
tb/wilder_rsi_stream_test.sv
